// ===== rtl/core/focvv_pkg.sv =====
// Shared types, widths and constants of the FOC current to voltage vector block.
package focvv_pkg;

   // Port field widths
   localparam int unsigned CURRENT_W = 16;
   localparam int unsigned VOLT_W    = 16;
   localparam int unsigned ANGLE_W   = 16;
   localparam int unsigned LIMIT_W   = 15;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd20480;

   // Clarke constants, Q0.16
   localparam logic [15:0] INV_SQRT6 = 16'd26755;
   localparam logic [15:0] INV_SQRT2 = 16'd46341;

   // CORDIC
   localparam int unsigned CORDIC_STEPS = 16;
   localparam int unsigned SC_W         = 18;   // sin/cos datapath, Q1.14 plus headroom
   localparam int unsigned Z_W          = 18;   // residual angle
   localparam int unsigned AT_W         = 33;   // vectoring datapath
   localparam int unsigned ARC_W        = 14;
   localparam int          QUARTER_TURN = 16384;
   localparam int          HALF_TURN    = 32768;
   localparam logic signed [SC_W-1:0] CORDIC_START = 18'sd9949;

   localparam logic [ARC_W-1:0] ARC_STEP [CORDIC_STEPS] = '{
      14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
      14'd41,   14'd20,   14'd10,   14'd5,    14'd3,   14'd1,   14'd1,   14'd0
   };

   // Datapath widths
   localparam int unsigned CLARKE_W = 25;
   localparam int unsigned PROD_W   = 34;
   localparam int unsigned VA_W     = 28;
   localparam int unsigned SUM_W    = 28;
   localparam int unsigned NUM_W    = 44;
   localparam int unsigned DEN_W    = SUM_W + 1;
   localparam int unsigned QUO_W    = LIMIT_W;

   // Pipeline latencies
   localparam int unsigned SC_LAT     = CORDIC_STEPS + 1;
   localparam int unsigned AT_LAT     = CORDIC_STEPS + 1;
   localparam int unsigned PIPE_DEPTH = 1 + SC_LAT + 4 + QUO_W + 1 + AT_LAT;

   typedef struct packed {
      logic signed [CURRENT_W-1:0] current_a;
      logic signed [CURRENT_W-1:0] current_b;
      logic signed [CURRENT_W-1:0] current_c;
      logic signed [CURRENT_W-1:0] torque_target;
      logic        [ANGLE_W-1:0]   rotor_angle;
   } req_type;

   typedef struct packed {
      logic signed [VOLT_W-1:0]  volt_alpha;
      logic signed [VOLT_W-1:0]  volt_beta;
      logic signed [ANGLE_W-1:0] vector_angle;
      logic                      zero_magnitude;
   } rsp_type;

endpackage

// ===== rtl/core/focvv_sincos.sv =====
// Pipelined rotation CORDIC: sine and cosine of a binary angle, one stage per step.
module focvv_sincos (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [focvv_pkg::ANGLE_W-1:0]        angle,
   output logic signed [focvv_pkg::SC_W-1:0]    sin_val,
   output logic signed [focvv_pkg::SC_W-1:0]    cos_val
);

   localparam int unsigned STEPS = focvv_pkg::CORDIC_STEPS;
   localparam int unsigned SW    = focvv_pkg::SC_W;
   localparam int unsigned ZW    = focvv_pkg::Z_W;

   logic signed [SW-1:0] x_ff    [STEPS+1];
   logic signed [SW-1:0] y_ff    [STEPS+1];
   logic signed [ZW-1:0] z_ff    [STEPS+1];
   logic                 flip_ff [STEPS+1];

   logic signed [ZW-1:0] z_ext;
   logic signed [ZW-1:0] z_fold_in;
   logic                 flip_in;

   // Fold the angle into the right half plane
   always_comb begin
      z_ext     = ZW'($signed(angle));
      z_fold_in = z_ext;
      flip_in   = 1'b0;
      if (z_ext > ZW'(focvv_pkg::QUARTER_TURN)) begin
         z_fold_in = z_ext - ZW'(focvv_pkg::HALF_TURN);
         flip_in   = 1'b1;
      end else if (z_ext < -ZW'(focvv_pkg::QUARTER_TURN)) begin
         z_fold_in = z_ext + ZW'(focvv_pkg::HALF_TURN);
         flip_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= focvv_pkg::CORDIC_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_fold_in;
         flip_ff[0] <= flip_in;
      end
   end

   // One micro-rotation per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic signed [SW-1:0] xs;
      logic signed [SW-1:0] ys;
      logic signed [ZW-1:0] arc;
      logic signed [SW-1:0] x_in;
      logic signed [SW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      always_comb begin
         xs  = x_ff[k] >>> k;
         ys  = y_ff[k] >>> k;
         arc = $signed(ZW'(focvv_pkg::ARC_STEP[k]));
         if (!z_ff[k][ZW-1]) begin
            x_in = x_ff[k] - ys;
            y_in = y_ff[k] + xs;
            z_in = z_ff[k] - arc;
         end else begin
            x_in = x_ff[k] + ys;
            y_in = y_ff[k] - xs;
            z_in = z_ff[k] + arc;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            flip_ff[k+1] <= flip_ff[k];
         end
      end
   end

   // Undo the fold
   assign cos_val = flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
   assign sin_val = flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];

endmodule

// ===== rtl/core/focvv_atan.sv =====
// Pipelined vectoring CORDIC: atan(b/a) of the scaled voltage vector.
module focvv_atan (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [focvv_pkg::VOLT_W-1:0]   a_val,
   input  logic signed [focvv_pkg::VOLT_W-1:0]   b_val,
   output logic signed [focvv_pkg::ANGLE_W-1:0]  angle
);

   localparam int unsigned STEPS = focvv_pkg::CORDIC_STEPS;
   localparam int unsigned AW    = focvv_pkg::AT_W;
   localparam int unsigned ZW    = focvv_pkg::Z_W;
   localparam int unsigned GW    = focvv_pkg::ANGLE_W;

   logic signed [AW-1:0] x_ff     [STEPS+1];
   logic signed [AW-1:0] y_ff     [STEPS+1];
   logic signed [ZW-1:0] z_ff     [STEPS+1];
   logic                 spec_ff  [STEPS+1];
   logic signed [GW-1:0] specv_ff [STEPS+1];

   logic signed [AW-1:0] a_ext;
   logic signed [AW-1:0] b_ext;
   logic signed [AW-1:0] x0_in;
   logic signed [AW-1:0] y0_in;
   logic signed [GW-1:0] specv_in;
   logic signed [ZW-1:0] z_last;
   logic signed [ZW-1:0] z_clamp;

   // Mirror into the right half plane, lift by 2^14; flag the vertical case
   always_comb begin
      a_ext = AW'(a_val);
      b_ext = AW'(b_val);
      if (a_val[GW-1]) begin
         x0_in = (-a_ext) <<< 14;
         y0_in = (-b_ext) <<< 14;
      end else begin
         x0_in = a_ext <<< 14;
         y0_in = b_ext <<< 14;
      end
      if (b_val > 0) begin
         specv_in = GW'(focvv_pkg::QUARTER_TURN);
      end else if (b_val < 0) begin
         specv_in = -GW'(focvv_pkg::QUARTER_TURN);
      end else begin
         specv_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]     <= x0_in;
         y_ff[0]     <= y0_in;
         z_ff[0]     <= '0;
         spec_ff[0]  <= (a_val == '0);
         specv_ff[0] <= specv_in;
      end
   end

   // Drive y toward zero, one step per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic signed [AW-1:0] xs;
      logic signed [AW-1:0] ys;
      logic signed [ZW-1:0] arc;
      logic signed [AW-1:0] x_in;
      logic signed [AW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      always_comb begin
         xs  = x_ff[k] >>> k;
         ys  = y_ff[k] >>> k;
         arc = $signed(ZW'(focvv_pkg::ARC_STEP[k]));
         if (!y_ff[k][AW-1]) begin
            x_in = x_ff[k] + ys;
            y_in = y_ff[k] - xs;
            z_in = z_ff[k] + arc;
         end else begin
            x_in = x_ff[k] - ys;
            y_in = y_ff[k] + xs;
            z_in = z_ff[k] - arc;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]     <= x_in;
            y_ff[k+1]     <= y_in;
            z_ff[k+1]     <= z_in;
            spec_ff[k+1]  <= spec_ff[k];
            specv_ff[k+1] <= specv_ff[k];
         end
      end
   end

   // Clamp to a quarter turn, or take the vertical answer
   always_comb begin
      z_last  = z_ff[STEPS];
      z_clamp = z_last;
      if (z_last > ZW'(focvv_pkg::QUARTER_TURN)) begin
         z_clamp = ZW'(focvv_pkg::QUARTER_TURN);
      end else if (z_last < -ZW'(focvv_pkg::QUARTER_TURN)) begin
         z_clamp = -ZW'(focvv_pkg::QUARTER_TURN);
      end
      angle = spec_ff[STEPS] ? specv_ff[STEPS] : GW'(z_clamp);
   end

endmodule

// ===== rtl/core/foc_current_to_voltage_vector.sv =====
// Top level: Clarke, folded Park/inverse Park, L1 scaling and vector angle pipeline.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------------
//   req     | req_valid req_stall req_data   | phase currents, torque, rotor angle
//   rsp     | rsp_valid rsp_stall rsp_data   | scaled alpha/beta, angle, zero flag
//   csr     | csr_valid csr_ready csr_data   | voltage limit (unsigned Q3.12)
//
// One word enters per cycle while req_stall is low; each accepted word then passes
// 1 Clarke stage, 17 sin/cos CORDIC, 4 Park/magnitude/multiply, 15 divider, 1 sign,
// 17 arctangent CORDIC and 1 output register, in that order.
// Reset clears the pipeline, output and skid valid bits and loads the limit with 5.0.
// A word that arrives while the output word is stalled parks in a skid register; the
// pipeline freezes only while that skid register is full, and req_stall is its valid bit.
module foc_current_to_voltage_vector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  focvv_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output focvv_pkg::rsp_type              rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [focvv_pkg::LIMIT_W-1:0]   csr_data
);

   localparam int unsigned DEPTH = focvv_pkg::PIPE_DEPTH;
   localparam int unsigned CW    = focvv_pkg::CLARKE_W;
   localparam int unsigned PW    = focvv_pkg::PROD_W;
   localparam int unsigned VW    = focvv_pkg::VA_W;
   localparam int unsigned SW    = focvv_pkg::SUM_W;
   localparam int unsigned NW    = focvv_pkg::NUM_W;
   localparam int unsigned DW    = focvv_pkg::DEN_W;
   localparam int unsigned QW    = focvv_pkg::QUO_W;
   localparam int unsigned OW    = focvv_pkg::VOLT_W;
   localparam int unsigned IW    = focvv_pkg::CURRENT_W;
   localparam int unsigned SCW   = focvv_pkg::SC_W;
   localparam int unsigned SCL   = focvv_pkg::SC_LAT;
   localparam int unsigned ATL   = focvv_pkg::AT_LAT;

   // Control
   logic                   en;
   logic                   accept;
   logic [DEPTH-1:0]       vld_ff;
   logic [DEPTH-1:0]       vld_in;
   logic [focvv_pkg::LIMIT_W-1:0] limit_ff;

   // Limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= focvv_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // Advance valid bits with the data
   logic skid_v_ff;
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign accept    = req_valid && !req_stall;
   assign vld_in    = {vld_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: Clarke transform
   logic signed [18:0]   diff_a;
   logic signed [17:0]   diff_b;
   logic signed [34:0]   cla_prod;
   logic signed [33:0]   clb_prod;
   logic signed [CW-1:0] al_in;
   logic signed [CW-1:0] be_in;
   logic signed [CW-1:0] al_p1_ff;
   logic signed [CW-1:0] be_p1_ff;
   logic signed [IW-1:0] tq_p1_ff;
   logic [focvv_pkg::ANGLE_W-1:0] ang_p1_ff;

   always_comb begin
      diff_a = (19'(req_data.current_a) <<< 1) - 19'(req_data.current_b)
             - 19'(req_data.current_c);
      diff_b = 18'(req_data.current_b) - 18'(req_data.current_c);
      cla_prod = 35'(diff_a) * $signed({19'd0, focvv_pkg::INV_SQRT6});
      clb_prod = 34'(diff_b) * $signed({18'd0, focvv_pkg::INV_SQRT2});
      al_in = CW'((cla_prod + 35'sd128) >>> 8);
      be_in = CW'((clb_prod + 34'sd128) >>> 8);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         al_p1_ff  <= al_in;
         be_p1_ff  <= be_in;
         tq_p1_ff  <= req_data.torque_target;
         ang_p1_ff <= req_data.rotor_angle;
      end
   end

   // Sine and cosine of the rotor angle
   logic signed [SCW-1:0] sin_w;
   logic signed [SCW-1:0] cos_w;

   focvv_sincos u_sincos (
      .clock   (clock),
      .en      (en),
      .angle   (ang_p1_ff),
      .sin_val (sin_w),
      .cos_val (cos_w)
   );

   // Delay Clarke results and torque alongside the CORDIC
   logic signed [CW-1:0] al_dly_ff [SCL];
   logic signed [CW-1:0] be_dly_ff [SCL];
   logic signed [IW-1:0] tq_dly_ff [SCL];

   always_ff @(posedge clock) begin
      if (en) begin
         al_dly_ff[0] <= al_p1_ff;
         be_dly_ff[0] <= be_p1_ff;
         tq_dly_ff[0] <= tq_p1_ff;
         for (int i = 1; i < SCL; i++) begin
            al_dly_ff[i] <= al_dly_ff[i-1];
            be_dly_ff[i] <= be_dly_ff[i-1];
            tq_dly_ff[i] <= tq_dly_ff[i-1];
         end
      end
   end

   // Stage: torque times sin and cos
   logic signed [PW-1:0] ps_ff;
   logic signed [PW-1:0] pc_ff;
   logic signed [CW-1:0] al_p2_ff;
   logic signed [CW-1:0] be_p2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff    <= PW'(tq_dly_ff[SCL-1]) * PW'(sin_w);
         pc_ff    <= PW'(tq_dly_ff[SCL-1]) * PW'(cos_w);
         al_p2_ff <= al_dly_ff[SCL-1];
         be_p2_ff <= be_dly_ff[SCL-1];
      end
   end

   // Stage: voltage rule folded with Park and inverse Park
   logic signed [PW:0]   term_s;
   logic signed [PW:0]   term_c;
   logic signed [VW-1:0] va_in;
   logic signed [VW-1:0] vb_in;
   logic signed [VW-1:0] va_ff;
   logic signed [VW-1:0] vb_ff;

   always_comb begin
      term_s = ((PW+1)'(ps_ff) + 35'sd16) >>> 5;
      term_c = ((PW+1)'(pc_ff) + 35'sd16) >>> 5;
      va_in  = VW'(-(PW+1)'(al_p2_ff) - term_s);
      vb_in  = VW'(-(PW+1)'(be_p2_ff) + term_c);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   // Stage: magnitudes and L1 sum
   logic [SW-1:0] mag_a_in;
   logic [SW-1:0] mag_b_in;
   logic [SW-1:0] mag_a_ff;
   logic [SW-1:0] mag_b_ff;
   logic [SW-1:0] sum_ff;
   logic          sa_p4_ff;
   logic          sb_p4_ff;

   always_comb begin
      mag_a_in = va_ff[VW-1] ? SW'(-va_ff) : SW'(va_ff);
      mag_b_in = vb_ff[VW-1] ? SW'(-vb_ff) : SW'(vb_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         sum_ff   <= mag_a_in + mag_b_in;
         sa_p4_ff <= va_ff[VW-1];
         sb_p4_ff <= vb_ff[VW-1];
      end
   end

   // Divider: element 0 holds numerator and denominator, element k+1 bits QW-1 to QW-1-k
   logic [NW-1:0] rem_a_ff [QW+1];
   logic [NW-1:0] rem_b_ff [QW+1];
   logic [QW-1:0] quo_a_ff [QW+1];
   logic [QW-1:0] quo_b_ff [QW+1];
   logic [DW-1:0] den_ff   [QW+1];
   logic          sa_ff    [QW+1];
   logic          sb_ff    [QW+1];
   logic          zero_ff  [QW+1];
   logic [NW-2:0] lim_a_prod;
   logic [NW-2:0] lim_b_prod;

   // Build 2*|v|*limit + sum and 2*sum
   always_comb begin
      lim_a_prod = (NW-1)'(mag_a_ff) * (NW-1)'(limit_ff);
      lim_b_prod = (NW-1)'(mag_b_ff) * (NW-1)'(limit_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_a_ff[0] <= {lim_a_prod, 1'b0} + NW'(sum_ff);
         rem_b_ff[0] <= {lim_b_prod, 1'b0} + NW'(sum_ff);
         quo_a_ff[0] <= '0;
         quo_b_ff[0] <= '0;
         den_ff[0]   <= {sum_ff, 1'b0};
         sa_ff[0]    <= sa_p4_ff;
         sb_ff[0]    <= sb_p4_ff;
         zero_ff[0]  <= (sum_ff == '0);
      end
   end

   // Restoring division, one quotient bit per stage, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int unsigned BIT = QW - 1 - k;
      logic [NW-1:0] dsh;
      logic          ge_a;
      logic          ge_b;

      always_comb begin
         dsh  = NW'(den_ff[k]) << BIT;
         ge_a = (rem_a_ff[k] >= dsh);
         ge_b = (rem_b_ff[k] >= dsh);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_a_ff[k+1] <= ge_a ? rem_a_ff[k] - dsh : rem_a_ff[k];
            rem_b_ff[k+1] <= ge_b ? rem_b_ff[k] - dsh : rem_b_ff[k];
            quo_a_ff[k+1] <= quo_a_ff[k] | (QW'(ge_a) << BIT);
            quo_b_ff[k+1] <= quo_b_ff[k] | (QW'(ge_b) << BIT);
            den_ff[k+1]   <= den_ff[k];
            sa_ff[k+1]    <= sa_ff[k];
            sb_ff[k+1]    <= sb_ff[k];
            zero_ff[k+1]  <= zero_ff[k];
         end
      end
   end

   // Stage: restore signs, force zero on an empty vector
   logic signed [OW-1:0] oa_in;
   logic signed [OW-1:0] ob_in;
   logic signed [OW-1:0] oa_p6_ff;
   logic signed [OW-1:0] ob_p6_ff;
   logic                 zero_p6_ff;

   always_comb begin
      oa_in = sa_ff[QW] ? -$signed({1'b0, quo_a_ff[QW]}) : $signed({1'b0, quo_a_ff[QW]});
      ob_in = sb_ff[QW] ? -$signed({1'b0, quo_b_ff[QW]}) : $signed({1'b0, quo_b_ff[QW]});
      if (zero_ff[QW]) begin
         oa_in = '0;
         ob_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         oa_p6_ff   <= oa_in;
         ob_p6_ff   <= ob_in;
         zero_p6_ff <= zero_ff[QW];
      end
   end

   // Vector angle
   logic signed [focvv_pkg::ANGLE_W-1:0] angle_w;

   focvv_atan u_atan (
      .clock (clock),
      .en    (en),
      .a_val (oa_p6_ff),
      .b_val (ob_p6_ff),
      .angle (angle_w)
   );

   logic signed [OW-1:0] oa_dly_ff   [ATL];
   logic signed [OW-1:0] ob_dly_ff   [ATL];
   logic                 zero_dly_ff [ATL];

   always_ff @(posedge clock) begin
      if (en) begin
         oa_dly_ff[0]   <= oa_p6_ff;
         ob_dly_ff[0]   <= ob_p6_ff;
         zero_dly_ff[0] <= zero_p6_ff;
         for (int i = 1; i < ATL; i++) begin
            oa_dly_ff[i]   <= oa_dly_ff[i-1];
            ob_dly_ff[i]   <= ob_dly_ff[i-1];
            zero_dly_ff[i] <= zero_dly_ff[i-1];
         end
      end
   end

   // Output register and skid register
   focvv_pkg::rsp_type pipe_word;
   focvv_pkg::rsp_type out_d_ff;
   focvv_pkg::rsp_type out_d_in;
   focvv_pkg::rsp_type skid_d_ff;
   focvv_pkg::rsp_type skid_d_in;
   logic               out_v_ff;
   logic               out_v_in;
   logic               skid_v_in;
   logic               pipe_v;
   logic               out_take;

   always_comb begin
      pipe_v                   = vld_ff[DEPTH-1];
      pipe_word.volt_alpha     = oa_dly_ff[ATL-1];
      pipe_word.volt_beta      = ob_dly_ff[ATL-1];
      pipe_word.vector_angle   = angle_w;
      pipe_word.zero_magnitude = zero_dly_ff[ATL-1];

      out_take  = out_v_ff && !rsp_stall;
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (skid_v_ff) begin
         // drain the parked word first
         if (out_take) begin
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || out_take) begin
         out_v_in = pipe_v;
         out_d_in = pipe_word;
      end else if (pipe_v) begin
         // hold the arriving word while the output waits
         skid_v_in = 1'b1;
         skid_d_in = pipe_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_d_ff;

endmodule

// ===== rtl/core/focvv_checker.sv =====
// Port checker for the FOC current to voltage vector block, with its bind.
module focvv_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input focvv_pkg::rsp_type rsp_data
);

   // Stalled word stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // Stalled word keeps its value
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed under stall");

   // Empty vector gives an all-zero word
   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_magnitude |->
         rsp_data.volt_alpha == '0 && rsp_data.volt_beta == '0 &&
         rsp_data.vector_angle == '0)
      else $error("zero_magnitude word carries nonzero fields");

   // Angle stays within a quarter turn either way
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.vector_angle <= 16'sd16384 &&
                    rsp_data.vector_angle >= -16'sd16384)
      else $error("vector_angle beyond a quarter turn");

   // Nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind foc_current_to_voltage_vector focvv_checker u_focvv_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/foc_current_to_voltage_vector_test.sv =====
// Self-checking bench for the FOC current to voltage vector pipeline.
`timescale 1ns / 1ps

module foc_current_to_voltage_vector_test;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_WORDS = 1100;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 400000;

   // Idle mix: no idling, sender idle, receiver stall, both
   typedef enum int {MIX_NONE, MIX_SEND, MIX_RECV, MIX_BOTH} idle_mix_type;

   localparam int ARC_TAB [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                   41, 20, 10, 5, 3, 1, 1, 0};

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   focvv_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   focvv_pkg::rsp_type rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [focvv_pkg::LIMIT_W-1:0] csr_data;

   focvv_pkg::rsp_type voltage_queue[$];
   logic [14:0]        limit_model;
   idle_mix_type       idle_mix;
   int                 fail_count;
   int                 cycle_count;

   foc_current_to_voltage_vector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Floor shift right of a signed value
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Rotation CORDIC: sine and cosine of a binary angle, Q1.14
   function automatic void sine_cosine(logic [15:0] angle, output longint s,
                                       output longint c);
      longint z, x, y, xs, ys;
      bit     flip;
      z = angle;
      flip = 1'b0;
      x = 9949;
      y = 0;
      if (z >= 32768) z -= 65536;
      if (z > focvv_pkg::QUARTER_TURN) begin
         z -= 32768;
         flip = 1'b1;
      end else if (z < -focvv_pkg::QUARTER_TURN) begin
         z += 32768;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= ARC_TAB[i];
         end else begin
            x += ys; y -= xs; z += ARC_TAB[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Vectoring CORDIC: angle of the scaled vector, clamped to a quarter turn
   function automatic longint vector_arctan(longint a, longint b);
      longint x, y, z, xs, ys;
      z = 0;
      if (a == 0) begin
         return (b > 0) ? focvv_pkg::QUARTER_TURN :
                ((b < 0) ? -focvv_pkg::QUARTER_TURN : 0);
      end
      if (a < 0) begin
         a = -a;
         b = -b;
      end
      x = a * 16384;
      y = b * 16384;
      for (int i = 0; i < 16; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += ARC_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ARC_TAB[i];
         end
      end
      if (z > focvv_pkg::QUARTER_TURN) z = focvv_pkg::QUARTER_TURN;
      if (z < -focvv_pkg::QUARTER_TURN) z = -focvv_pkg::QUARTER_TURN;
      return z;
   endfunction

   function automatic longint l1_scale(longint v, longint total, longint lim);
      longint mag, q;
      mag = v < 0 ? -v : v;
      q = (2 * mag * lim + total) / (2 * total);
      return v < 0 ? -q : q;
   endfunction

   function automatic focvv_pkg::rsp_type predict_voltage(focvv_pkg::req_type w);
      longint             ia, ib, ic, t, s, c, al, be, va, vb, total, oa, ob;
      focvv_pkg::rsp_type r;
      ia = w.current_a;
      ib = w.current_b;
      ic = w.current_c;
      t  = w.torque_target;
      al = floor_shift((2 * ia - ib - ic) * 26755 + 128, 8);
      be = floor_shift((ib - ic) * 46341 + 128, 8);
      sine_cosine(w.rotor_angle, s, c);
      va = -al - floor_shift(2 * t * s + 32, 6);
      vb = -be + floor_shift(2 * t * c + 32, 6);
      total = (va < 0 ? -va : va) + (vb < 0 ? -vb : vb);
      r = '0;
      if (total == 0) begin
         r.zero_magnitude = 1'b1;
      end else begin
         oa = l1_scale(va, total, limit_model);
         ob = l1_scale(vb, total, limit_model);
         r.volt_alpha   = oa[15:0];
         r.volt_beta    = ob[15:0];
         r.vector_angle = 16'(vector_arctan(oa, ob));
      end
      return r;
   endfunction

   // Random sender gaps and receiver stalls by phase
   function automatic bit sender_idles();
      return (idle_mix == MIX_SEND || idle_mix == MIX_BOTH) &&
             $urandom_range(99) < ((idle_mix == MIX_BOTH) ? 23 : 68);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (idle_mix == MIX_RECV || idle_mix == MIX_BOTH) &&
                      $urandom_range(99) < ((idle_mix == MIX_BOTH) ? 23 : 68);
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      focvv_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (voltage_queue.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_data);
            fail_count++;
         end else begin
            e = voltage_queue.pop_front();
            if (rsp_data.volt_alpha !== e.volt_alpha) begin
               $error("volt_alpha expected %0d actual %0d", e.volt_alpha, rsp_data.volt_alpha);
               fail_count++;
            end
            if (rsp_data.volt_beta !== e.volt_beta) begin
               $error("volt_beta expected %0d actual %0d", e.volt_beta, rsp_data.volt_beta);
               fail_count++;
            end
            if (rsp_data.vector_angle !== e.vector_angle) begin
               $error("vector_angle expected %0d actual %0d",
                      e.vector_angle, rsp_data.vector_angle);
               fail_count++;
            end
            if (rsp_data.zero_magnitude !== e.zero_magnitude) begin
               $error("zero_magnitude expected %0d actual %0d",
                      e.zero_magnitude, rsp_data.zero_magnitude);
               fail_count++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** foc_current_to_voltage_vector: FAILED **");
         $finish;
      end
   end

   // Send one word, holding it until accepted; optional gap first.
   // Valid stays high afterwards so words can follow back to back.
   task automatic send_word(focvv_pkg::req_type w, bit with_gaps);
      while (with_gaps && sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      voltage_queue.push_back(predict_voltage(w));
   endtask

   // Send one word after checking the given result against the model's prediction
   task automatic send_known(focvv_pkg::req_type w, focvv_pkg::rsp_type known);
      focvv_pkg::rsp_type p;
      p = predict_voltage(w);
      if (p !== known) begin
         $error("table row disagrees with prediction: %h vs %h", known, p);
         fail_count++;
      end
      send_word(w, 1'b0);
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (voltage_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_limit(logic [14:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_model = value;
   endtask

   function automatic focvv_pkg::req_type random_word();
      focvv_pkg::req_type w;
      w = focvv_pkg::req_type'(80'({$urandom, $urandom, $urandom}));
      case ($urandom_range(7))
         0: begin
            w.current_b = w.current_a;
            w.current_c = w.current_a;
         end
         1: w.torque_target = '0;
         2: w.rotor_angle = 16'($urandom_range(3) * 16384);
         3: begin
            w.current_a = 16'($signed($urandom_range(64)) - 32);
            w.current_b = 16'($signed($urandom_range(64)) - 32);
            w.current_c = 16'($signed($urandom_range(64)) - 32);
            w.torque_target = 16'($signed($urandom_range(16)) - 8);
         end
         default: ;
      endcase
      return w;
   endfunction

   typedef struct {
      focvv_pkg::req_type word;
      logic [1:0]         kind;   // 1: forced zero result, any other value: predicted
   } stim_row_type;

   stim_row_type stim_table [20];

   initial begin
      focvv_pkg::rsp_type known;
      int                 limits [6];
      limits = '{0, 32767, 1, 4096, 20480, 12345};
      fail_count  = 0;
      cycle_count = 0;
      idle_mix    = MIX_NONE;
      limit_model = focvv_pkg::LIMIT_RESET;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;

      // Directed rows: extremes, zero vector, axis-aligned cases
      stim_table = '{
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 2'd1},
         '{'{16'sd100, 16'sd100, 16'sd100, 16'sd0, 16'd12345}, 2'd1},
         '{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'hFFFF}, 2'd1},
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'd0}, 2'd0},
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'd16384}, 2'd0},
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'd32768}, 2'd0},
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'd49152}, 2'd0},
         '{'{16'sd0, 16'sd0, 16'sd0, -16'sd256, 16'd8192}, 2'd0},
         '{'{16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 16'd0}, 2'd0},
         '{'{-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'hFFFF}, 2'd0},
         '{'{16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 16'h8000}, 2'd0},
         '{'{16'sd512, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 2'd0},
         '{'{-16'sd512, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 2'd0},
         '{'{16'sd0, 16'sd256, -16'sd256, 16'sd0, 16'd0}, 2'd0},
         '{'{16'sd0, -16'sd256, 16'sd256, 16'sd0, 16'd0}, 2'd0},
         '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'd16383}, 2'd0},
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'd16385}, 2'd0},
         '{'{16'sd300, -16'sd200, 16'sd50, 16'sd1000, 16'd40000}, 2'd0},
         '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 2'd0},
         '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 2'd0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset limit
      foreach (stim_table[i]) begin
         known = '0;
         if (stim_table[i].kind == 2'd1) begin
            known.zero_magnitude = 1'b1;
            send_known(stim_table[i].word, known);
         end else begin
            send_word(stim_table[i].word, 1'b0);
         end
      end
      wait_drained();

      // Random part: each limit setting paired with an idle mix
      for (int p = 0; p < 6; p++) begin
         write_limit(15'(limits[p]));
         idle_mix = idle_mix_type'(p % 4);
         for (int n = 0; n < RANDOM_WORDS / 6; n++) begin
            send_word(random_word(), 1'b1);
            if (p == 2 && n == 50) wait_drained();
         end
         wait_drained();
      end

      idle_mix = MIX_NONE;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && voltage_queue.size() == 0) begin
         $display("** foc_current_to_voltage_vector: PASSED **");
      end else begin
         $display("** foc_current_to_voltage_vector: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/focvv_pkg.sv
rtl/core/focvv_sincos.sv
rtl/core/focvv_atan.sv
rtl/core/foc_current_to_voltage_vector.sv
rtl/core/focvv_checker.sv
bench/foc_current_to_voltage_vector_test.sv
